/* sv/modbus_rtu_master_read_regs_core_assert.svh */
// Assertion macros for the read-holding-registers master core.
`ifndef MODBUS_RTU_MASTER_READ_REGS_CORE_ASSERT_SVH
`define MODBUS_RTU_MASTER_READ_REGS_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock.
`define MBRTU_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock.
`define MBRTU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* sv/mbrtu_pkg.sv */
package mbrtu_pkg;

   typedef enum logic [1:0] {
      CMD_REQUEST    = 2'd0,
      CMD_RX_BYTE    = 2'd1,
      CMD_TICK       = 2'd2,
      CMD_TABLE_READ = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      KIND_TX     = 2'd0,
      KIND_STATUS = 2'd1,
      KIND_READ   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_CRC_ERROR = 2'd1,
      STAT_TIMEOUT   = 2'd2
   } status_type;

   localparam logic [7:0]  FC_READ_HOLD  = 8'h03;
   localparam logic [15:0] CRC_INIT      = 16'hFFFF;
   localparam logic [15:0] CRC_POLY      = 16'hA001;
   localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
   localparam int          REQ_LEN       = 8;
   localparam int          REQ_BODY      = 6;
   // frame read index: reaches 3 + 2 * 127
   localparam int          FIDX_W        = 9;

   typedef struct packed {
      logic       clr_wr;
      logic       latch;
      logic       req_init;
      logic       tx_step;
      logic       rx_take;
      logic       rx_end;
      logic       tick;
      logic       trd_issue;
      logic       f_rd;
      logic       f_cap;
      logic       copy_init;
      logic       out_load;
      kind_type   out_kind;
      status_type out_status;
   } mbrtu_cmd_type;

   typedef struct packed {
      logic        clr_done;
      command_type hold_cmd;
      logic        hold_fend;
      logic        rx_crc_ok;
      logic        tick_timeout;
      logic        tx_last;
      logic        hdr_done;
      logic        frame_good;
      logic        words_zero;
      logic        word_last;
      logic        out_free;
   } mbrtu_stat_type;

   function automatic logic [15:0] crc_fold(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      int          k;
      c = crc ^ {8'h00, b};
      for (k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

/* sv/mbrtu_ram.sv */
module mbrtu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

/* sv/mbrtu_ctrl.sv */
module mbrtu_ctrl
   import mbrtu_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  mbrtu_stat_type st,
   output mbrtu_cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_DISP, S_TX, S_STAT, S_TRD,
      S_H_RD, S_H_CAP, S_CHECK, S_W_RD, S_W_CAP, S_OK
   } state_type;

   state_type  state_ff, state_in;
   logic       phase_ff, phase_in;
   status_type stat_ff, stat_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         phase_ff <= 1'b0;
         stat_ff  <= STAT_OK;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         stat_ff  <= stat_in;
      end
   end

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      phase_in  = phase_ff;
      stat_in   = stat_ff;
      req_stall = (state_ff != S_IDLE);
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (st.clr_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_DISP;
            end
         end
         S_DISP: begin
            state_in = S_IDLE;
            case (st.hold_cmd)
               CMD_REQUEST: begin
                  if (!phase_ff) begin
                     cmd.req_init = 1'b1;
                     phase_in     = 1'b1;
                     state_in     = S_TX;
                  end
               end
               CMD_RX_BYTE: begin
                  if (phase_ff) begin
                     cmd.rx_take = 1'b1;
                     if (st.hold_fend) begin
                        cmd.rx_end = 1'b1;
                        if (st.rx_crc_ok) begin
                           state_in = S_H_RD;
                        end else begin
                           stat_in  = STAT_CRC_ERROR;
                           state_in = S_STAT;
                        end
                     end
                  end
               end
               CMD_TICK: begin
                  if (phase_ff) begin
                     cmd.tick = 1'b1;
                     if (st.tick_timeout) begin
                        phase_in = 1'b0;
                        stat_in  = STAT_TIMEOUT;
                        state_in = S_STAT;
                     end
                  end
               end
               CMD_TABLE_READ: begin
                  cmd.trd_issue = 1'b1;
                  state_in      = S_TRD;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_TX: begin
            if (st.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = KIND_TX;
               cmd.tx_step  = 1'b1;
               if (st.tx_last) state_in = S_IDLE;
            end
         end
         S_STAT: begin
            if (st.out_free) begin
               cmd.out_load   = 1'b1;
               cmd.out_kind   = KIND_STATUS;
               cmd.out_status = stat_ff;
               state_in       = S_IDLE;
            end
         end
         S_TRD: begin
            if (st.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = KIND_READ;
               state_in     = S_IDLE;
            end
         end
         S_H_RD: begin
            cmd.f_rd = 1'b1;
            state_in = S_H_CAP;
         end
         S_H_CAP: begin
            cmd.f_cap = 1'b1;
            state_in  = st.hdr_done ? S_CHECK : S_H_RD;
         end
         S_CHECK: begin
            if (st.frame_good) begin
               cmd.copy_init = 1'b1;
               state_in      = st.words_zero ? S_OK : S_W_RD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_W_RD: begin
            cmd.f_rd = 1'b1;
            state_in = S_W_CAP;
         end
         S_W_CAP: begin
            cmd.f_cap = 1'b1;
            state_in  = st.word_last ? S_OK : S_W_RD;
         end
         S_OK: begin
            phase_in = 1'b0;
            if (st.out_free) begin
               cmd.out_load   = 1'b1;
               cmd.out_kind   = KIND_STATUS;
               cmd.out_status = STAT_OK;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

/* sv/mbrtu_dp.sv */
module mbrtu_dp
   import mbrtu_pkg::*;
#(
   parameter int NUM_SLAVES     = 8,
   parameter int REGS_PER_SLAVE = 64,
   parameter int FRAME_BYTES    = 256
) (
   input  logic           clock,
   input  logic           reset,
   input  logic [1:0]     req_command,
   input  logic [7:0]     req_slave_id,
   input  logic [15:0]    req_start_register,
   input  logic [15:0]    req_register_count,
   input  logic [7:0]     req_rx_byte,
   input  logic           req_frame_end,
   input  logic           csr_write_en,
   input  logic [15:0]    csr_write_data,
   input  mbrtu_cmd_type  cmd,
   output mbrtu_stat_type st,
   input  logic           rsp_stall,
   output logic           rsp_valid,
   output logic [1:0]     rsp_result_kind,
   output logic [7:0]     rsp_tx_byte,
   output logic [1:0]     rsp_status,
   output logic [15:0]    rsp_read_value,
   output logic           rsp_last
);

   localparam int TBL_DEPTH = NUM_SLAVES * REGS_PER_SLAVE;
   localparam int TBL_AW    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
   localparam int FR_AW     = $clog2(FRAME_BYTES);
   localparam int CNT_W     = $clog2(FRAME_BYTES + 1);

   logic [15:0]       timeout_ff;
   command_type       hold_cmd_ff;
   logic [7:0]        hold_id_ff;
   logic [15:0]       hold_start_ff;
   logic [15:0]       hold_count_ff;
   logic [7:0]        hold_byte_ff;
   logic              hold_fend_ff;
   logic [15:0]       pending_start_ff;
   logic [15:0]       wait_ff, wait_in;
   logic [15:0]       rcrc_ff, rcrc_in;
   logic [CNT_W-1:0]  rx_count_ff;
   logic [2:0]        txk_ff;
   logic [15:0]       txcrc_ff;
   logic [TBL_AW-1:0] clr_ff;
   logic [FIDX_W-1:0] fidx_ff;
   logic              fzero_ff;
   logic [7:0]        id_rx_ff, fc_ff, bc_ff, hi_ff;
   logic [6:0]        words_ff;
   logic [TBL_AW-1:0] taddr_ff;
   logic              trd_ok_ff;
   logic              rsp_valid_ff;
   logic [1:0]        kind_ff;
   logic [7:0]        tx_ff;
   logic [1:0]        status_ff;
   logic [15:0]       value_ff;
   logic              last_ff;

   logic [7:0]        tx_byte;
   logic [7:0]        fr_rd_data, fbyte;
   logic              fr_wr_en;
   logic              word_pos, lo_pos;
   logic              tbl_wr_en;
   logic [TBL_AW-1:0] tbl_wr_addr, tbl_rd_addr, copy_base;
   logic [15:0]       tbl_wr_data, tbl_rd_data;
   logic              trd_ok;
   logic [16:0]       span_end;

   always_comb begin
      case (txk_ff)
         3'd0:    tx_byte = hold_id_ff;
         3'd1:    tx_byte = FC_READ_HOLD;
         3'd2:    tx_byte = hold_start_ff[15:8];
         3'd3:    tx_byte = hold_start_ff[7:0];
         3'd4:    tx_byte = hold_count_ff[15:8];
         3'd5:    tx_byte = hold_count_ff[7:0];
         3'd6:    tx_byte = txcrc_ff[7:0];
         default: tx_byte = txcrc_ff[15:8];
      endcase
   end

   assign rcrc_in  = crc_fold(rcrc_ff, hold_byte_ff);
   assign wait_in  = (wait_ff == 16'hFFFF) ? wait_ff : wait_ff + 16'd1;
   assign fbyte    = fzero_ff ? 8'h00 : fr_rd_data;
   assign word_pos = (fidx_ff > FIDX_W'(3));
   assign lo_pos   = word_pos && fidx_ff[0];
   assign span_end = {1'b0, pending_start_ff} + {10'd0, bc_ff[7:1]};
   assign trd_ok   = (hold_id_ff != 8'd0) && (hold_id_ff <= 8'(NUM_SLAVES))
                     && (hold_start_ff < 16'(REGS_PER_SLAVE));
   assign copy_base = TBL_AW'(({24'd0, id_rx_ff} - 32'd1) * 32'(REGS_PER_SLAVE)
                              + {16'd0, pending_start_ff});
   assign tbl_rd_addr = TBL_AW'(({24'd0, hold_id_ff} - 32'd1) * 32'(REGS_PER_SLAVE)
                                + {16'd0, hold_start_ff});

   assign fr_wr_en    = cmd.rx_take && (rx_count_ff < CNT_W'(FRAME_BYTES));
   assign tbl_wr_en   = cmd.clr_wr || (cmd.f_cap && lo_pos);
   assign tbl_wr_addr = cmd.clr_wr ? clr_ff : taddr_ff;
   assign tbl_wr_data = cmd.clr_wr ? 16'h0000 : {hi_ff, fbyte};

   mbrtu_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_frame (
      .clock   (clock),
      .wr_en   (fr_wr_en),
      .wr_addr (rx_count_ff[FR_AW-1:0]),
      .wr_data (hold_byte_ff),
      .rd_en   (cmd.f_rd),
      .rd_addr (fidx_ff[FR_AW-1:0]),
      .rd_data (fr_rd_data)
   );

   mbrtu_ram #(.WIDTH(16), .DEPTH(TBL_DEPTH)) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_en   (cmd.trd_issue),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= TIMEOUT_RESET;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         rx_count_ff  <= '0;
         rcrc_ff      <= CRC_INIT;
         wait_ff      <= '0;
      end else begin
         if (csr_write_en) timeout_ff <= csr_write_data;
         if (cmd.clr_wr) clr_ff <= clr_ff + TBL_AW'(1);
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.req_init) begin
            wait_ff     <= '0;
            rcrc_ff     <= CRC_INIT;
            rx_count_ff <= '0;
         end
         if (cmd.tick) wait_ff <= wait_in;
         if (cmd.rx_take) begin
            rcrc_ff <= rcrc_in;
            if (fr_wr_en) rx_count_ff <= rx_count_ff + CNT_W'(1);
         end
         if (cmd.rx_end) begin
            rcrc_ff     <= CRC_INIT;
            rx_count_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         hold_cmd_ff   <= command_type'(req_command);
         hold_id_ff    <= req_slave_id;
         hold_start_ff <= req_start_register;
         hold_count_ff <= req_register_count;
         hold_byte_ff  <= req_rx_byte;
         hold_fend_ff  <= req_frame_end;
      end
      if (cmd.req_init) begin
         pending_start_ff <= hold_start_ff;
         txk_ff           <= '0;
         txcrc_ff         <= CRC_INIT;
      end
      if (cmd.tx_step) begin
         txk_ff <= txk_ff + 3'd1;
         if (txk_ff < 3'(REQ_BODY)) txcrc_ff <= crc_fold(txcrc_ff, tx_byte);
      end
      if (cmd.rx_end) fidx_ff <= '0;
      if (cmd.f_rd) begin
         fzero_ff <= (fidx_ff >= FIDX_W'(FRAME_BYTES));
         fidx_ff  <= fidx_ff + FIDX_W'(1);
      end
      if (cmd.f_cap) begin
         if (fidx_ff == FIDX_W'(1)) begin
            id_rx_ff <= fbyte;
         end else if (fidx_ff == FIDX_W'(2)) begin
            fc_ff <= fbyte;
         end else if (fidx_ff == FIDX_W'(3)) begin
            bc_ff <= fbyte;
         end else if (!fidx_ff[0]) begin
            hi_ff <= fbyte;
         end else begin
            taddr_ff <= taddr_ff + TBL_AW'(1);
            words_ff <= words_ff - 7'd1;
         end
      end
      if (cmd.copy_init) begin
         taddr_ff <= copy_base;
         words_ff <= bc_ff[7:1];
      end
      if (cmd.trd_issue) trd_ok_ff <= trd_ok;
      if (cmd.out_load) begin
         kind_ff   <= cmd.out_kind;
         tx_ff     <= (cmd.out_kind == KIND_TX) ? tx_byte : 8'h00;
         status_ff <= (cmd.out_kind == KIND_STATUS) ? cmd.out_status : STAT_OK;
         value_ff  <= (cmd.out_kind == KIND_READ && trd_ok_ff) ? tbl_rd_data : 16'h0000;
         last_ff   <= (cmd.out_kind == KIND_TX) && (txk_ff == 3'(REQ_LEN - 1));
      end
   end

   always_comb begin
      st              = '0;
      st.clr_done     = (clr_ff == TBL_AW'(TBL_DEPTH - 1));
      st.hold_cmd     = hold_cmd_ff;
      st.hold_fend    = hold_fend_ff;
      st.rx_crc_ok    = (rcrc_in == 16'h0000);
      st.tick_timeout = (wait_in >= timeout_ff);
      st.tx_last      = (txk_ff == 3'(REQ_LEN - 1));
      st.hdr_done     = (fidx_ff == FIDX_W'(3));
      st.frame_good   = (fc_ff == FC_READ_HOLD) && (id_rx_ff != 8'd0)
                        && (id_rx_ff <= 8'(NUM_SLAVES))
                        && (span_end <= 17'(REGS_PER_SLAVE));
      st.words_zero   = (bc_ff[7:1] == 7'd0);
      st.word_last    = lo_pos && (words_ff == 7'd1);
      st.out_free     = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = kind_ff;
   assign rsp_tx_byte     = tx_ff;
   assign rsp_status      = status_ff;
   assign rsp_read_value  = value_ff;
   assign rsp_last        = last_ff;

endmodule

/* sv/modbus_rtu_master_read_regs_core.sv */
// Modbus RTU master core, read holding registers (function 0x03).
// Input channel (req_*): one transfer carries a command: send request, received
// reply byte (with frame_end on the last byte), timer tick, or table read.
// Result channel (rsp_*): transmit bytes (last on the eighth), status reports
// (ok, crc error, timeout) and table read words.
// csr_write_en/csr_write_data set timeout_ticks (1000 after reset).
// Sequence: a command is latched when taken and decoded in the next cycle. A
// request then emits its 8 frame bytes one per cycle while the result channel
// does not stall. A byte or tick is handled in S_DISP, a table read goes on to
// S_TRD. A good reply frame walks the frame buffer with the single read port:
// header bytes in S_H_RD/S_H_CAP, then each stored word in S_W_RD/S_W_CAP, then
// one status. Reset: the register table is cleared by a pass over its
// NUM_SLAVES * REGS_PER_SLAVE entries (512 by default) with req_stall high.
// The result register lets a new transfer in while a result waits; while
// rsp_stall is high the controller holds in the emitting state and req_stall
// stays high once the next command needs the output.
`include "modbus_rtu_master_read_regs_core_assert.svh"

module modbus_rtu_master_read_regs_core
   import mbrtu_pkg::*;
#(
   parameter int NUM_SLAVES     = 8,
   parameter int REGS_PER_SLAVE = 64,
   parameter int FRAME_BYTES    = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_slave_id,
   input  logic [15:0] req_start_register,
   input  logic [15:0] req_register_count,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_frame_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_result_kind,
   output logic [7:0]  rsp_tx_byte,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_read_value,
   output logic        rsp_last,
   input  logic        csr_write_en,
   input  logic [15:0] csr_write_data
);

   mbrtu_cmd_type  cmd;
   mbrtu_stat_type st;

   mbrtu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .st        (st),
      .cmd       (cmd)
   );

   mbrtu_dp #(
      .NUM_SLAVES     (NUM_SLAVES),
      .REGS_PER_SLAVE (REGS_PER_SLAVE),
      .FRAME_BYTES    (FRAME_BYTES)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_command        (req_command),
      .req_slave_id       (req_slave_id),
      .req_start_register (req_start_register),
      .req_register_count (req_register_count),
      .req_rx_byte        (req_rx_byte),
      .req_frame_end      (req_frame_end),
      .csr_write_en       (csr_write_en),
      .csr_write_data     (csr_write_data),
      .cmd                (cmd),
      .st                 (st),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_tx_byte        (rsp_tx_byte),
      .rsp_status         (rsp_status),
      .rsp_read_value     (rsp_read_value),
      .rsp_last           (rsp_last)
   );

   `MBRTU_ASSERT_NOW(a_last_on_tx, clock, reset, rsp_valid && rsp_last, rsp_result_kind == KIND_TX)
   `MBRTU_ASSERT_NOW(a_tx_zero, clock, reset, rsp_valid && rsp_result_kind != KIND_TX, rsp_tx_byte == 8'h00)
   `MBRTU_ASSERT_NOW(a_clear_stalls, clock, reset, cmd.clr_wr, req_stall)
   `MBRTU_ASSERT_NEXT(a_decode_stalls, clock, reset, req_valid && !req_stall, req_stall)

endmodule

/* bench/tb_modbus_rtu_master_read_regs_core.sv */
module tb_modbus_rtu_master_read_regs_core;
   import mbrtu_pkg::*;

   localparam int NSLV       = 8;
   localparam int NREG       = 64;
   localparam int FBYTES     = 256;
   localparam int STALL_PCT  = 13;
   localparam int WDOG_LIMIT = 20000;
   localparam int SETTLE     = 40;
   localparam int PHASE_ITEMS = 36;

   typedef struct {
      logic [1:0]  cmd;
      logic [7:0]  id;
      logic [15:0] start;
      logic [15:0] count;
      logic [7:0]  rxb;
      logic        fend;
   } req_item_type;

   typedef struct {
      logic [1:0]  kind;
      logic [7:0]  tx;
      logic [1:0]  st;
      logic [15:0] val;
      logic        last;
   } rsp_item_type;

   typedef enum int {D_PRED, D_NONE, D_TIMEOUT, D_ZERO_READ, D_CFG} dmode_type;

   typedef struct {
      req_item_type it;
      dmode_type    mode;
      logic [15:0]  cfg;
   } drow_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_command;
   logic [7:0]  req_slave_id;
   logic [15:0] req_start_register;
   logic [15:0] req_register_count;
   logic [7:0]  req_rx_byte;
   logic        req_frame_end;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_result_kind;
   logic [7:0]  rsp_tx_byte;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_read_value;
   logic        rsp_last;
   logic        csr_write_en;
   logic [15:0] csr_write_data;

   modbus_rtu_master_read_regs_core dut (.*);

   // predictor state
   bit          waiting;
   logic [15:0] pend_start;
   logic [15:0] wait_cnt;
   logic [15:0] rx_crc;
   logic [15:0] tmo_ticks;
   int          rx_n;
   logic [7:0]  fbuf [FBYTES];
   logic [15:0] reg_table [NSLV*NREG];

   rsp_item_type expected_q[$];
   bit          failed;
   bit          calm;
   bit          hold_req;
   int          hold_cnt;
   int          idle_cycles;
   int          sent;
   drow_type    dir_tab[20];

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic logic [15:0] crc16_step(logic [15:0] c, logic [7:0] b);
      logic [15:0] r;
      r = c ^ {8'h00, b};
      for (int k = 0; k < 8; k++) r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
      return r;
   endfunction

   function automatic logic [7:0] fbyte(int i);
      return (i < FBYTES) ? fbuf[i] : 8'h00;
   endfunction

   function automatic req_item_type mk(logic [1:0] c, logic [7:0] id, logic [15:0] s,
                                       logic [15:0] n, logic [7:0] b, logic f);
      req_item_type r;
      r.cmd = c; r.id = id; r.start = s; r.count = n; r.rxb = b; r.fend = f;
      return r;
   endfunction

   task automatic push_rsp(logic [1:0] k, logic [7:0] tx, logic [1:0] st,
                           logic [15:0] v, logic l, bit keep);
      rsp_item_type e;
      e.kind = k; e.tx = tx; e.st = st; e.val = v; e.last = l;
      if (keep) expected_q.push_back(e);
   endtask

   function automatic bit store_reply();
      int id, words, base;
      if (fbyte(1) != FC_READ_HOLD) return 0;
      id = fbyte(0);
      if (id == 0 || id > NSLV) return 0;
      words = fbyte(2) >> 1;
      if (int'(pend_start) + words > NREG) return 0;
      base = (id - 1) * NREG + int'(pend_start);
      for (int i = 0; i < words; i++)
         reg_table[base + i] = {fbyte(3 + 2*i), fbyte(4 + 2*i)};
      return 1;
   endfunction

   task automatic master_step(req_item_type it, bit keep);
      logic [7:0]  fr[8];
      logic [15:0] c;
      bit          ok;
      int          idx;
      case (it.cmd)
         CMD_REQUEST: if (!waiting) begin
            fr[0] = it.id; fr[1] = FC_READ_HOLD;
            fr[2] = it.start[15:8]; fr[3] = it.start[7:0];
            fr[4] = it.count[15:8]; fr[5] = it.count[7:0];
            c = 16'hFFFF;
            for (int k = 0; k < 6; k++) c = crc16_step(c, fr[k]);
            fr[6] = c[7:0]; fr[7] = c[15:8];
            for (int k = 0; k < 8; k++) push_rsp(KIND_TX, fr[k], STAT_OK, 0, k == 7, keep);
            waiting = 1; pend_start = it.start; wait_cnt = 0;
            rx_crc = 16'hFFFF; rx_n = 0;
         end
         CMD_RX_BYTE: if (waiting) begin
            if (rx_n < FBYTES) begin
               fbuf[rx_n] = it.rxb;
               rx_n++;
            end
            rx_crc = crc16_step(rx_crc, it.rxb);
            if (it.fend) begin
               ok = (rx_crc == 0);
               if (ok && store_reply()) begin
                  waiting = 0;
                  push_rsp(KIND_STATUS, 0, STAT_OK, 0, 0, keep);
               end else if (!ok) begin
                  push_rsp(KIND_STATUS, 0, STAT_CRC_ERROR, 0, 0, keep);
               end
               rx_crc = 16'hFFFF; rx_n = 0;
            end
         end
         CMD_TICK: if (waiting) begin
            if (wait_cnt != 16'hFFFF) wait_cnt++;
            if (wait_cnt >= tmo_ticks) begin
               waiting = 0;
               push_rsp(KIND_STATUS, 0, STAT_TIMEOUT, 0, 0, keep);
            end
         end
         default: begin
            idx = (int'(it.id) - 1) * NREG + int'(it.start);
            if (it.id >= 1 && it.id <= NSLV && it.start < NREG)
               push_rsp(KIND_READ, 0, STAT_OK, reg_table[idx], 0, keep);
            else
               push_rsp(KIND_READ, 0, STAT_OK, 0, 0, keep);
         end
      endcase
   endtask

   task automatic send_req(req_item_type it, bit keep);
      if (!calm && $urandom_range(99) < STALL_PCT) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      master_step(it, keep);
      req_valid          <= 1;
      req_command        <= it.cmd;
      req_slave_id       <= it.id;
      req_start_register <= it.start;
      req_register_count <= it.count;
      req_rx_byte        <= it.rxb;
      req_frame_end      <= it.fend;
      do @(posedge clock); while (req_stall);
      sent++;
   endtask

   task automatic drain();
      req_valid <= 0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_timeout(logic [15:0] v);
      drain();
      csr_write_en   <= 1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_en   <= 0;
      tmo_ticks = v;
   endtask

   task automatic send_reply(logic [7:0] id, logic [7:0] fc, int words, bit odd,
                             bit corrupt);
      logic [7:0]  fr[$];
      logic [15:0] c;
      int          p;
      fr = {};
      fr.push_back(id);
      fr.push_back(fc);
      fr.push_back(8'(2 * words + odd));
      for (int i = 0; i < 2 * words + odd; i++) fr.push_back(8'($urandom));
      c = 16'hFFFF;
      foreach (fr[i]) c = crc16_step(c, fr[i]);
      fr.push_back(c[7:0]);
      fr.push_back(c[15:8]);
      if (corrupt) begin
         p = $urandom_range(fr.size() - 1);
         fr[p] = fr[p] ^ (8'h01 << $urandom_range(7));
      end
      foreach (fr[i])
         send_req(mk(CMD_RX_BYTE, 8'($urandom), 16'($urandom), 16'($urandom),
                     fr[i], i == fr.size() - 1), 1);
   endtask

   task automatic random_part(int n);
      int          r, s, w, target;
      logic [7:0]  id;
      target = sent + n;
      while (sent < target) begin
         r = $urandom_range(99);
         if (r < 60) begin
            id = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(1, NSLV));
            s  = $urandom_range(NREG - 1);
            w  = $urandom_range(0, (NREG - s < 8) ? NREG - s : 8);
            if ($urandom_range(9) == 0) s = $urandom_range(NREG - 4, 65535);
            send_req(mk(CMD_REQUEST, id, 16'(s), 16'($urandom), 8'($urandom),
                        1'($urandom)), 1);
            repeat ($urandom_range(0, 2))
               send_req(mk(CMD_TICK, 8'($urandom), 16'($urandom), 16'($urandom),
                           8'($urandom), 1'($urandom)), 1);
            if ($urandom_range(9) == 0) id = 8'($urandom);
            send_reply(id, ($urandom_range(9) == 0) ? 8'($urandom) : FC_READ_HOLD, w,
                       $urandom_range(7) == 0, $urandom_range(9) == 0);
         end else if (r < 75) begin
            repeat ($urandom_range(1, 4))
               send_req(mk(CMD_TABLE_READ, 8'($urandom_range(0, NSLV + 1)),
                           16'($urandom_range(0, NREG)), 16'($urandom), 8'($urandom),
                           1'($urandom)), 1);
         end else begin
            send_req(mk(2'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                        8'($urandom), $urandom_range(3) == 0), 1);
         end
      end
   endtask

   // result side stall
   always @(posedge clock) begin
      if (hold_cnt > 0) begin
         rsp_stall <= 1;
         hold_cnt = hold_cnt - 1;
      end else if (hold_req) begin
         hold_req = 0;
         hold_cnt = 400;
         rsp_stall <= 1;
      end else if (calm) begin
         rsp_stall <= 0;
      end else begin
         rsp_stall <= ($urandom_range(99) < STALL_PCT);
      end
   end

   always @(posedge clock) begin
      rsp_item_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            $error("unexpected result transfer kind %0d", rsp_result_kind);
            failed = 1;
         end else begin
            e = expected_q.pop_front();
            if (rsp_result_kind !== e.kind) begin
               $error("result_kind exp %0d got %0d", e.kind, rsp_result_kind);
               failed = 1;
            end
            if (rsp_tx_byte !== e.tx) begin
               $error("tx_byte exp %0h got %0h", e.tx, rsp_tx_byte);
               failed = 1;
            end
            if (rsp_status !== e.st) begin
               $error("status exp %0d got %0d", e.st, rsp_status);
               failed = 1;
            end
            if (rsp_read_value !== e.val) begin
               $error("read_value exp %0h got %0h", e.val, rsp_read_value);
               failed = 1;
            end
            if (rsp_last !== e.last) begin
               $error("last exp %0d got %0d", e.last, rsp_last);
               failed = 1;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin
      logic [15:0] tmo_set[5];
      reset = 1; req_valid = 0; req_command = CMD_TICK; req_slave_id = 0;
      req_start_register = 0; req_register_count = 0; req_rx_byte = 0;
      req_frame_end = 0; rsp_stall = 0; csr_write_en = 0; csr_write_data = 0;
      failed = 0; calm = 0; hold_req = 0; hold_cnt = 0; idle_cycles = 0; sent = 0;
      waiting = 0; pend_start = 0; wait_cnt = 0; rx_crc = 16'hFFFF; rx_n = 0;
      tmo_ticks = TIMEOUT_RESET;
      foreach (fbuf[i]) fbuf[i] = 0;
      foreach (reg_table[i]) reg_table[i] = 0;

      dir_tab[0]  = '{mk(CMD_TABLE_READ, 1, 0, 0, 0, 0), D_ZERO_READ, 0};
      dir_tab[1]  = '{mk(CMD_TABLE_READ, 0, 0, 0, 0, 0), D_ZERO_READ, 0};
      dir_tab[2]  = '{mk(CMD_TABLE_READ, 9, 5, 0, 0, 0), D_ZERO_READ, 0};
      dir_tab[3]  = '{mk(CMD_TABLE_READ, 8, 63, 16'hFFFF, 8'hFF, 1), D_ZERO_READ, 0};
      dir_tab[4]  = '{mk(CMD_TABLE_READ, 8, 64, 0, 0, 0), D_ZERO_READ, 0};
      dir_tab[5]  = '{mk(CMD_TABLE_READ, 8'hFF, 16'hFFFF, 0, 0, 0), D_ZERO_READ, 0};
      dir_tab[6]  = '{mk(CMD_RX_BYTE, 1, 0, 0, 8'hFF, 1), D_NONE, 0};
      dir_tab[7]  = '{mk(CMD_TICK, 1, 0, 0, 0, 0), D_NONE, 0};
      dir_tab[8]  = '{mk(CMD_REQUEST, 8'hFF, 16'hFFFF, 16'hFFFF, 0, 0), D_PRED, 0};
      dir_tab[9]  = '{mk(CMD_REQUEST, 1, 0, 1, 0, 0), D_NONE, 0};
      dir_tab[10] = '{mk(CMD_RX_BYTE, 0, 0, 0, 8'h00, 0), D_NONE, 0};
      dir_tab[11] = '{mk(CMD_TICK, 0, 0, 0, 0, 0), D_NONE, 0};
      dir_tab[12] = '{mk(CMD_TICK, 0, 0, 0, 0, 0), D_CFG, 16'd1};
      dir_tab[13] = '{mk(CMD_TICK, 0, 0, 0, 0, 0), D_TIMEOUT, 0};
      dir_tab[14] = '{mk(CMD_REQUEST, 0, 0, 0, 0, 0), D_PRED, 0};
      dir_tab[15] = '{mk(CMD_RX_BYTE, 0, 0, 0, 8'hAA, 0), D_NONE, 0};
      dir_tab[16] = '{mk(CMD_TICK, 0, 0, 0, 0, 0), D_TIMEOUT, 0};
      dir_tab[17] = '{mk(CMD_REQUEST, 1, 16'h1234, 16'h007D, 0, 0), D_PRED, 0};
      dir_tab[18] = '{mk(CMD_TICK, 0, 0, 0, 0, 0), D_CFG, 16'hFFFF};
      dir_tab[19] = '{mk(CMD_TICK, 0, 0, 0, 0, 0), D_NONE, 0};

      repeat (8) @(posedge clock);
      reset <= 0;

      foreach (dir_tab[i]) begin
         case (dir_tab[i].mode)
            D_CFG:       write_timeout(dir_tab[i].cfg);
            D_PRED:      send_req(dir_tab[i].it, 1);
            D_NONE:      send_req(dir_tab[i].it, 0);
            D_TIMEOUT: begin
               push_rsp(KIND_STATUS, 0, STAT_TIMEOUT, 0, 0, 1);
               send_req(dir_tab[i].it, 0);
            end
            D_ZERO_READ: begin
               push_rsp(KIND_READ, 0, STAT_OK, 0, 0, 1);
               send_req(dir_tab[i].it, 0);
            end
            default: ;
         endcase
      end

      // overlong frame: fills the whole buffer and runs past it
      for (int i = 0; i < FBYTES + 2; i++)
         send_req(mk(CMD_RX_BYTE, 0, 0, 0, 8'($urandom), i == FBYTES + 1), 1);

      tmo_set = '{16'd1, 16'hFFFF, 16'd3, TIMEOUT_RESET, 16'($urandom_range(2, 30))};
      foreach (tmo_set[p]) begin
         write_timeout(tmo_set[p]);
         calm = (p == 2);
         if (p == 1) hold_req = 1;
         random_part(PHASE_ITEMS);
      end
      calm = 0;
      drain();

      if (!failed && expected_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
